FILE: hdl/crb_pkg.sv
// crb_pkg: shared types and constants of the color replace blend pipeline
package crb_pkg;

    localparam int COLOR_W = 8;
    localparam int LIMIT_W = 10;
    localparam int LIM2_W  = 2 * LIMIT_W;
    localparam int QUO_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_OLD_RED   = 3'd0,
        REG_OLD_GREEN = 3'd1,
        REG_OLD_BLUE  = 3'd2,
        REG_NEW_RED   = 3'd3,
        REG_NEW_GREEN = 3'd4,
        REG_NEW_BLUE  = 3'd5,
        REG_LIMIT     = 3'd6
    } crb_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] in_red;
        logic [COLOR_W-1:0] in_green;
        logic [COLOR_W-1:0] in_blue;
        logic [COLOR_W-1:0] in_alpha;
    } pix_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] out_alpha;
    } pix_out_t;

    typedef struct packed {
        logic [LIM2_W-1:0] rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
    } div_t;

    typedef struct packed {
        pix_in_t pix;
        logic    match;
        div_t    div;
    } crb_lane_t;

endpackage

FILE: hdl/color_replace_blend.sv
// color_replace_blend: top level, redmean distance and blend toward a new color
//
//  channel   direction  handshake              payload
//  src       in         src_valid/src_stall    src_word (pix_in_t)
//  dst       out        dst_valid/dst_stall    dst_word (pix_out_t)
//  apb       in/out     psel/penable/pready    paddr, pwdata, prdata
//
// one word per cycle while the output is not stalled, 21 register stages
// most of these stages are the 16 one-bit steps of the pipelined divider
// reset clears the configuration and the valid bits, emptying the pipeline
// a stalled output word freezes the whole pipeline, src_stall follows
module color_replace_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [crb_pkg::ADDR_W-1:0] paddr,
    input  logic [crb_pkg::DATA_W-1:0] pwdata,
    output logic [crb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       src_valid,
    output logic                       src_stall,
    input  crb_pkg::pix_in_t           src_word,
    output logic                       dst_valid,
    input  logic                       dst_stall,
    output crb_pkg::pix_out_t          dst_word
);
    import crb_pkg::*;

    localparam int NSTEP = QUO_W;

    // configuration
    logic [COLOR_W-1:0] old_red_reg, old_green_reg, old_blue_reg;
    logic [COLOR_W-1:0] new_red_reg, new_green_reg, new_blue_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIM2_W-1:0]  lim2_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_red_reg   <= '0;
            old_green_reg <= '0;
            old_blue_reg  <= '0;
            new_red_reg   <= '0;
            new_green_reg <= '0;
            new_blue_reg  <= '0;
            limit_reg     <= '0;
            lim2_reg      <= '0;
        end
        else
        begin
            lim2_reg <= limit_reg * limit_reg;
            if (wr_en)
            begin
                unique case (paddr[4:2])
                    REG_OLD_RED:   old_red_reg   <= pwdata[COLOR_W-1:0];
                    REG_OLD_GREEN: old_green_reg <= pwdata[COLOR_W-1:0];
                    REG_OLD_BLUE:  old_blue_reg  <= pwdata[COLOR_W-1:0];
                    REG_NEW_RED:   new_red_reg   <= pwdata[COLOR_W-1:0];
                    REG_NEW_GREEN: new_green_reg <= pwdata[COLOR_W-1:0];
                    REG_NEW_BLUE:  new_blue_reg  <= pwdata[COLOR_W-1:0];
                    REG_LIMIT:     limit_reg     <= pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_OLD_RED:   prdata[COLOR_W-1:0] = old_red_reg;
            REG_OLD_GREEN: prdata[COLOR_W-1:0] = old_green_reg;
            REG_OLD_BLUE:  prdata[COLOR_W-1:0] = old_blue_reg;
            REG_NEW_RED:   prdata[COLOR_W-1:0] = new_red_reg;
            REG_NEW_GREEN: prdata[COLOR_W-1:0] = new_green_reg;
            REG_NEW_BLUE:  prdata[COLOR_W-1:0] = new_blue_reg;
            REG_LIMIT:     prdata[LIMIT_W-1:0] = limit_reg;
            default: ;
        endcase
    end

    // pipeline advance
    logic out_valid_reg;
    logic adv;

    assign adv       = !(out_valid_reg && dst_stall);
    assign src_stall = !adv;

    // stage 1: differences, squares and red sum
    logic        s1_valid_reg;
    pix_in_t     s1_pix_reg;
    logic [15:0] s1_dr2_reg, s1_dg2_reg, s1_db2_reg;
    logic [8:0]  s1_rsum_reg;
    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] dr_sq, dg_sq, db_sq;

    always_comb
    begin
        dr    = $signed({1'b0, src_word.in_red})   - $signed({1'b0, old_red_reg});
        dg    = $signed({1'b0, src_word.in_green}) - $signed({1'b0, old_green_reg});
        db    = $signed({1'b0, src_word.in_blue})  - $signed({1'b0, old_blue_reg});
        dr_sq = dr * dr;
        dg_sq = dg * dg;
        db_sq = db * db;
    end

    // stage 2: weighted sum and redmean term
    logic               s2_valid_reg;
    pix_in_t            s2_pix_reg;
    logic [19:0]        s2_wsum_reg;
    logic signed [26:0] s2_prod_reg;
    logic signed [16:0] sq_diff;

    assign sq_diff = $signed({1'b0, s1_dr2_reg}) - $signed({1'b0, s1_db2_reg});

    // stage 3: distance, match test, divider setup
    logic               s3_valid_reg;
    crb_lane_t          s3_lane_reg;
    logic signed [30:0] dsum;
    logic [28:0]        dfix;
    crb_lane_t          s3_lane_next;

    always_comb
    begin
        dsum = $signed({2'b0, s2_wsum_reg, 9'b0}) + $signed({{4{s2_prod_reg[26]}}, s2_prod_reg});
        dfix = dsum[30] ? '0 : dsum[28:0];
        s3_lane_next.pix       = s2_pix_reg;
        s3_lane_next.match     = (lim2_reg != '0) && (dfix < {lim2_reg, 9'b0});
        s3_lane_next.div.rem   = dfix[28:9];
        s3_lane_next.div.num   = {dfix[8:0], 7'b0};
        s3_lane_next.div.quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= src_word;
            s1_dr2_reg  <= dr_sq[15:0];
            s1_dg2_reg  <= dg_sq[15:0];
            s1_db2_reg  <= db_sq[15:0];
            s1_rsum_reg <= {1'b0, src_word.in_red} + {1'b0, old_red_reg};
            s2_pix_reg  <= s1_pix_reg;
            s2_wsum_reg <= {3'b0, s1_dr2_reg, 1'b0} + {2'b0, s1_dg2_reg, 2'b0}
                         + {3'b0, s1_db2_reg, 1'b0} + {4'b0, s1_db2_reg};
            s2_prod_reg <= $signed({1'b0, s1_rsum_reg}) * sq_diff;
            s3_lane_reg <= s3_lane_next;
        end
    end

    // divider: one quotient bit per stage
    logic [NSTEP:0] div_valid;
    crb_lane_t      div_lane [0:NSTEP];

    assign div_valid[0] = s3_valid_reg;
    assign div_lane[0]  = s3_lane_reg;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_div
        crb_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .lim2    (lim2_reg),
            .valid_i (div_valid[i]),
            .lane_i  (div_lane[i]),
            .valid_o (div_valid[i+1]),
            .lane_o  (div_lane[i+1])
        );
    end

    // blend products
    logic        b1_valid_reg;
    pix_in_t     b1_pix_reg;
    logic        b1_match_reg;
    logic [24:0] b1_nr_reg, b1_ng_reg, b1_nb_reg;
    logic [23:0] b1_sr_reg, b1_sg_reg, b1_sb_reg;
    logic [16:0] inv_c;
    logic [15:0] c16;
    crb_lane_t   dl;

    assign dl    = div_lane[NSTEP];
    assign c16   = dl.div.quo;
    assign inv_c = 17'h10000 - {1'b0, c16};

    // output stage
    pix_out_t    out_word_reg;
    pix_out_t    out_word_next;
    logic [25:0] sum_r, sum_g, sum_b;

    always_comb
    begin
        sum_r = {1'b0, b1_nr_reg} + {2'b0, b1_sr_reg};
        sum_g = {1'b0, b1_ng_reg} + {2'b0, b1_sg_reg};
        sum_b = {1'b0, b1_nb_reg} + {2'b0, b1_sb_reg};
        if (b1_match_reg)
        begin
            out_word_next.out_red   = (|sum_r[25:24]) ? 8'hFF : sum_r[23:16];
            out_word_next.out_green = (|sum_g[25:24]) ? 8'hFF : sum_g[23:16];
            out_word_next.out_blue  = (|sum_b[25:24]) ? 8'hFF : sum_b[23:16];
            out_word_next.out_alpha = 8'hFF;
        end
        else
        begin
            out_word_next.out_red   = b1_pix_reg.in_red;
            out_word_next.out_green = b1_pix_reg.in_green;
            out_word_next.out_blue  = b1_pix_reg.in_blue;
            out_word_next.out_alpha = b1_pix_reg.in_alpha;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= div_valid[NSTEP];
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_pix_reg   <= dl.pix;
            b1_match_reg <= dl.match;
            b1_nr_reg    <= new_red_reg * inv_c;
            b1_ng_reg    <= new_green_reg * inv_c;
            b1_nb_reg    <= new_blue_reg * inv_c;
            b1_sr_reg    <= dl.pix.in_red * c16;
            b1_sg_reg    <= dl.pix.in_green * c16;
            b1_sb_reg    <= dl.pix.in_blue * c16;
            out_word_reg <= out_word_next;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_word  = out_word_reg;

endmodule

FILE: hdl/crb_div_step.sv
// crb_div_step: one registered restoring division step, one quotient bit
module crb_div_step (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [crb_pkg::LIM2_W-1:0] lim2,
    input  logic                      valid_i,
    input  crb_pkg::crb_lane_t        lane_i,
    output logic                      valid_o,
    output crb_pkg::crb_lane_t        lane_o
);
    import crb_pkg::*;

    logic              valid_reg;
    crb_lane_t         lane_reg;
    crb_lane_t         lane_next;
    logic [LIM2_W:0]   trial;
    logic [LIM2_W:0]   diff;
    logic              qbit;

    always_comb
    begin
        trial = {lane_i.div.rem, lane_i.div.num[QUO_W-1]};
        diff  = trial - {1'b0, lim2};
        qbit  = (trial >= {1'b0, lim2});
        lane_next = lane_i;
        lane_next.div.rem = qbit ? diff[LIM2_W-1:0] : trial[LIM2_W-1:0];
        lane_next.div.num = {lane_i.div.num[QUO_W-2:0], 1'b0};
        lane_next.div.quo = {lane_i.div.quo[QUO_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg <= lane_next;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o  = lane_reg;

endmodule

FILE: bench/tb_color_replace_blend.sv
// tb_color_replace_blend: self-checking testbench of the color replace blend pipeline
`timescale 1ns / 1ps

module tb_color_replace_blend;

    import crb_pkg::*;

    localparam int LATENCY     = 21;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                src_valid;
    logic                src_stall;
    pix_in_t             src_word;
    logic                dst_valid;
    logic                dst_stall;
    pix_out_t            dst_word;

    logic [7:0] old_r, old_g, old_b, new_r, new_g, new_b;
    logic [9:0] limit;

    pix_out_t   expected_pixels[$];
    int         src_idle_pct;
    int         dst_stall_pct;
    int         errors;
    int         cycles;

    color_replace_blend i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] blend(logic [7:0] n, logic [7:0] s, longint c16);
        longint v;
        begin
            v = (longint'(n) * (65536 - c16) + longint'(s) * c16) >>> 16;
            blend = (v > 255) ? 8'd255 : v[7:0];
        end
    endfunction

    function automatic pix_out_t replace_pixel(pix_in_t p);
        longint   dr, dg, db, dr2, dg2, db2, dfix, lim2, c16;
        pix_out_t o;
        begin
            dr   = longint'(p.in_red) - longint'(old_r);
            dg   = longint'(p.in_green) - longint'(old_g);
            db   = longint'(p.in_blue) - longint'(old_b);
            dr2  = dr * dr;
            dg2  = dg * dg;
            db2  = db * db;
            dfix = 512 * (2 * dr2 + 4 * dg2 + 3 * db2)
                   + (longint'(p.in_red) + longint'(old_r)) * (dr2 - db2);
            if (dfix < 0)
                dfix = 0;
            lim2 = longint'(limit) * longint'(limit);
            if (lim2 != 0 && dfix < 512 * lim2)
            begin
                c16 = (dfix * 128) / lim2;
                if (c16 > 65535)
                    c16 = 65535;
                o.out_red   = blend(new_r, p.in_red, c16);
                o.out_green = blend(new_g, p.in_green, c16);
                o.out_blue  = blend(new_b, p.in_blue, c16);
                o.out_alpha = 8'd255;
            end
            else
            begin
                o = {p.in_red, p.in_green, p.in_blue, p.in_alpha};
            end
            replace_pixel = o;
        end
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** color_replace_blend: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        dst_stall <= ($urandom_range(99) < dst_stall_pct);
    end

    // compare each word leaving the block with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, dst_word);
                errors++;
            end
            else
            begin
                pix_out_t e;
                e = expected_pixels.pop_front();
                if (e.out_red !== dst_word.out_red)
                begin
                    $display("%0t: red exp %0d got %0d", $time, e.out_red, dst_word.out_red);
                    errors++;
                end
                if (e.out_green !== dst_word.out_green)
                begin
                    $display("%0t: green exp %0d got %0d", $time, e.out_green,
                             dst_word.out_green);
                    errors++;
                end
                if (e.out_blue !== dst_word.out_blue)
                begin
                    $display("%0t: blue exp %0d got %0d", $time, e.out_blue,
                             dst_word.out_blue);
                    errors++;
                end
                if (e.out_alpha !== dst_word.out_alpha)
                begin
                    $display("%0t: alpha exp %0d got %0d", $time, e.out_alpha,
                             dst_word.out_alpha);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(crb_reg_t idx, logic [DATA_W-1:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(4 * int'(idx));
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            case (idx)
                REG_OLD_RED:   old_r = value[7:0];
                REG_OLD_GREEN: old_g = value[7:0];
                REG_OLD_BLUE:  old_b = value[7:0];
                REG_NEW_RED:   new_r = value[7:0];
                REG_NEW_GREEN: new_g = value[7:0];
                REG_NEW_BLUE:  new_b = value[7:0];
                default:       limit = value[9:0];
            endcase
        end
    endtask

    task automatic drain;
        begin
            src_valid <= 1'b0;
            while (expected_pixels.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 4)
                @(posedge clk);
        end
    endtask

    task automatic set_colors(logic [7:0] or_, logic [7:0] og, logic [7:0] ob,
                              logic [7:0] nr, logic [7:0] ng, logic [7:0] nb,
                              logic [9:0] lim);
        begin
            drain();
            write_reg(REG_OLD_RED, or_);
            write_reg(REG_OLD_GREEN, og);
            write_reg(REG_OLD_BLUE, ob);
            write_reg(REG_NEW_RED, nr);
            write_reg(REG_NEW_GREEN, ng);
            write_reg(REG_NEW_BLUE, nb);
            write_reg(REG_LIMIT, lim);
        end
    endtask

    task automatic send_pixel(pix_in_t p);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
            src_valid <= 1'b1;
            src_word  <= p;
            @(posedge clk);
            while (src_stall)
                @(posedge clk);
            expected_pixels.push_back(replace_pixel(p));
        end
    endtask

    function automatic pix_in_t near_old(int spread);
        pix_in_t p;
        int      v;
        begin
            v = int'(old_r) + $urandom_range(2 * spread) - spread;
            p.in_red   = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            v = int'(old_g) + $urandom_range(2 * spread) - spread;
            p.in_green = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            v = int'(old_b) + $urandom_range(2 * spread) - spread;
            p.in_blue  = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            p.in_alpha = 8'($urandom);
            near_old = p;
        end
    endfunction

    task automatic test_reset_passthrough;
        begin
            send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
            send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
            send_pixel('{8'h5a, 8'ha5, 8'h3c, 8'hc3});
        end
    endtask

    task automatic test_directed;
        begin
            set_colors(8'd200, 8'd40, 8'd90, 8'd10, 8'd250, 8'd128, 10'd200);
            send_pixel('{8'd200, 8'd40, 8'd90, 8'd7});
            send_pixel('{8'd201, 8'd40, 8'd90, 8'd7});
            send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
            send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
            send_pixel('{8'd180, 8'd60, 8'd70, 8'd33});
            set_colors(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 10'd1023);
            send_pixel('{8'd255, 8'd255, 8'd255, 8'd1});
            send_pixel('{8'd0, 8'd0, 8'd0, 8'd2});
            send_pixel('{8'd128, 8'd128, 8'd128, 8'd3});
            send_pixel('{8'd0, 8'd255, 8'd0, 8'd4});
            set_colors(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 10'd1);
            send_pixel('{8'd0, 8'd0, 8'd0, 8'd9});
            send_pixel('{8'd1, 8'd0, 8'd0, 8'd9});
            send_pixel('{8'd0, 8'd0, 8'd1, 8'd9});
            // zero limit disables replacement, even on the exact color
            set_colors(8'd17, 8'd34, 8'd51, 8'd99, 8'd99, 8'd99, 10'd0);
            send_pixel('{8'd17, 8'd34, 8'd51, 8'd66});
            send_pixel('{8'd18, 8'd34, 8'd51, 8'd66});
        end
    endtask

    task automatic test_random(int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                if (i % 60 == 0)
                    set_colors(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom),
                               (i % 180 == 0) ? 10'd1023 : 10'($urandom_range(1023)));
                if ($urandom_range(3) == 0)
                    send_pixel(pix_in_t'($urandom));
                else
                    send_pixel(near_old(1 + $urandom_range(limit / 4 + 2)));
            end
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        src_valid = 1'b0;
        src_word  = '0;
        dst_stall = 1'b0;
        errors    = 0;
        cycles    = 0;
        {old_r, old_g, old_b, new_r, new_g, new_b} = '0;
        limit         = '0;
        src_idle_pct  = 23;
        dst_stall_pct = 84;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_passthrough();
        test_directed();
        test_random(320);
        // sender holds off until the pipeline is empty
        drain();
        src_idle_pct  = 84;
        dst_stall_pct = 23;
        test_random(320);
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        test_random(300);
        drain();

        if (errors == 0)
            $display("** color_replace_blend: PASSED **");
        else
            $display("** color_replace_blend: FAILED **");
        $finish;
    end

endmodule
